// ===== hdl/antd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the active note table with decay.
// Used by the front, back and top modules; depends on nothing.

package antd_pkg;

    localparam int NOTE_W   = 7;
    localparam int VOICE_W  = 4;
    localparam int VEL_W    = 7;
    localparam int VOL_W    = 15;
    localparam int FACT_W   = 8;
    localparam int FRAC_W   = 8;
    localparam int REQ_W    = 2;
    localparam int PROD_W   = VOL_W + FACT_W;

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    localparam logic [FACT_W-1:0] DECAY_RESET = 8'd243;

    // Request codes as they arrive on req_type
    typedef enum logic [REQ_W-1:0] {
        REQ_NOTE_ON   = 2'd0,
        REQ_NOTE_OFF  = 2'd1,
        REQ_FRAME_END = 2'd2
    } req_t;

    // Classified command handed from the front to the back
    typedef struct packed {
        req_t               kind;
        logic [NOTE_W-1:0]  note;
        logic [VOICE_W-1:0] voice;
        logic [VEL_W-1:0]   velocity;
    } cmd_t;

    // One table entry as stored in the table RAM
    typedef struct packed {
        logic [NOTE_W-1:0]  note;
        logic [VOICE_W-1:0] voice;
        logic [VOL_W-1:0]   volume;
    } entry_t;

    // One result word
    typedef struct packed {
        logic               entry_valid;
        logic [NOTE_W-1:0]  note;
        logic [VOICE_W-1:0] voice;
        logic [VOL_W-1:0]   volume;
        logic               last_entry;
        logic               overflow_seen;
    } result_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ON_READ,
        S_ON_CHECK,
        S_ON_APPEND,
        S_OFF_READ,
        S_OFF_CHECK,
        S_SHIFT_READ,
        S_SHIFT_WRITE,
        S_FRAME_READ,
        S_FRAME_EMIT,
        S_EMPTY
    } back_state_t;

endpackage

// ===== hdl/antd_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.

module antd_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port; hold data when not reading
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/antd_fifo.sv =====
`timescale 1ns / 1ps
// Small register FIFO with first-word-fall-through head.
// Stand-alone; no package needed.

module antd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Advance pointers with explicit wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/antd_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts request words, drops unused codes, queues commands.
// Depends on antd_pkg and antd_fifo.

module antd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [antd_pkg::REQ_W-1:0]    req_type,
    input  logic [antd_pkg::NOTE_W-1:0]   note_number,
    input  logic [antd_pkg::VOICE_W-1:0]  channel_voice,
    input  logic [antd_pkg::VEL_W-1:0]    note_velocity,
    input  logic                          cmd_pop,
    output logic                          cmd_empty,
    output antd_pkg::cmd_t                cmd_word
);

    antd_pkg::cmd_t cmd_in;
    logic           keep;
    logic           cmd_push;
    logic           queue_full;
    logic [$bits(antd_pkg::cmd_t)-1:0] queue_rdata;

    // Classify the request; unused codes are accepted and dropped
    always_comb
    begin
        cmd_in.note     = note_number;
        cmd_in.voice    = channel_voice;
        cmd_in.velocity = note_velocity;
        cmd_in.kind     = antd_pkg::REQ_NOTE_ON;
        keep            = 1'b0;
        unique case (req_type)
            antd_pkg::REQ_NOTE_ON:
            begin
                cmd_in.kind = antd_pkg::REQ_NOTE_ON;
                keep        = 1'b1;
            end
            antd_pkg::REQ_NOTE_OFF:
            begin
                cmd_in.kind = antd_pkg::REQ_NOTE_OFF;
                keep        = 1'b1;
            end
            antd_pkg::REQ_FRAME_END:
            begin
                cmd_in.kind = antd_pkg::REQ_FRAME_END;
                keep        = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full     = queue_full;
    assign cmd_push = push && !queue_full && keep;

    antd_fifo #(
        .WIDTH ($bits(antd_pkg::cmd_t)),
        .DEPTH (antd_pkg::CMD_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (queue_full),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .rdata (queue_rdata)
    );

    assign cmd_word = queue_rdata;

endmodule

// ===== hdl/antd_back.sv =====
`timescale 1ns / 1ps
// Back end: sequencer that walks the note table RAM for each command,
// emits result words into the result queue and applies the frame decay.
// Depends on antd_pkg, antd_ram and antd_fifo.

module antd_back #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [antd_pkg::FACT_W-1:0]   decay_factor,
    input  antd_pkg::cmd_t                cmd_word,
    input  logic                          cmd_empty,
    output logic                          cmd_pop,
    input  logic                          res_pop,
    output logic                          res_empty,
    output antd_pkg::result_t             res_word
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $bits(antd_pkg::entry_t);
    localparam int RW = $bits(antd_pkg::result_t);

    antd_pkg::back_state_t state_reg, state_next;
    antd_pkg::cmd_t        cmd_reg, cmd_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  overflow_reg, overflow_next;

    logic                  ram_wr_en;
    logic [IW-1:0]         ram_wr_addr;
    antd_pkg::entry_t      ram_wr_entry;
    logic                  ram_rd_en;
    logic [IW-1:0]         ram_rd_addr;
    logic [EW-1:0]         ram_rd_data;
    antd_pkg::entry_t      rd_entry;

    logic                  res_push;
    logic                  res_full;
    antd_pkg::result_t     res_data;
    logic [RW-1:0]         res_rdata;

    logic [CW-1:0]             idx_plus1;
    logic [CW-1:0]             idx_plus2;
    logic [antd_pkg::PROD_W-1:0] decay_prod;
    logic [antd_pkg::VOL_W-1:0]  decayed_volume;
    logic [antd_pkg::VOL_W-1:0]  onset_volume;

    assign rd_entry       = ram_rd_data;
    assign idx_plus1      = CW'(idx_reg) + CW'(1);
    assign idx_plus2      = CW'(idx_reg) + CW'(2);
    assign decay_prod     = antd_pkg::PROD_W'(rd_entry.volume)
                          * antd_pkg::PROD_W'(decay_factor);
    assign decayed_volume = decay_prod[antd_pkg::PROD_W-1:antd_pkg::FACT_W];
    assign onset_volume   = {cmd_reg.velocity, {antd_pkg::FRAC_W{1'b0}}};

    // Sequence one command at a time over the table
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        cmd_pop       = 1'b0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = idx_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = idx_reg;
        ram_wr_entry  = rd_entry;
        res_push      = 1'b0;
        res_data      = '0;

        unique case (state_reg)
            antd_pkg::S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_word;
                    idx_next = '0;
                    unique case (cmd_word.kind)
                        antd_pkg::REQ_NOTE_ON:
                            state_next = (count_reg == '0) ? antd_pkg::S_ON_APPEND
                                                           : antd_pkg::S_ON_READ;
                        antd_pkg::REQ_NOTE_OFF:
                            state_next = (count_reg == '0) ? antd_pkg::S_IDLE
                                                           : antd_pkg::S_OFF_READ;
                        antd_pkg::REQ_FRAME_END:
                            state_next = (count_reg == '0) ? antd_pkg::S_EMPTY
                                                           : antd_pkg::S_FRAME_READ;
                        default:
                            state_next = antd_pkg::S_IDLE;
                    endcase
                end
            end

            // Note-on: search for the note, update in place or append
            antd_pkg::S_ON_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = antd_pkg::S_ON_CHECK;
            end
            antd_pkg::S_ON_CHECK:
            begin
                if (rd_entry.note == cmd_reg.note)
                begin
                    ram_wr_en    = 1'b1;
                    ram_wr_entry = '{note: rd_entry.note, voice: cmd_reg.voice,
                                     volume: onset_volume};
                    state_next   = antd_pkg::S_IDLE;
                end
                else if (idx_plus1 == count_reg)
                begin
                    state_next = antd_pkg::S_ON_APPEND;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = antd_pkg::S_ON_READ;
                end
            end
            antd_pkg::S_ON_APPEND:
            begin
                if (count_reg < CW'(TABLE_DEPTH))
                begin
                    ram_wr_en    = 1'b1;
                    ram_wr_addr  = count_reg[IW-1:0];
                    ram_wr_entry = '{note: cmd_reg.note, voice: cmd_reg.voice,
                                     volume: onset_volume};
                    count_next   = count_reg + CW'(1);
                end
                else
                begin
                    overflow_next = 1'b1;
                end
                state_next = antd_pkg::S_IDLE;
            end

            // Note-off: search, then pull later entries down by one
            antd_pkg::S_OFF_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = antd_pkg::S_OFF_CHECK;
            end
            antd_pkg::S_OFF_CHECK:
            begin
                if (rd_entry.note == cmd_reg.note)
                begin
                    if (idx_plus1 == count_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = antd_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = antd_pkg::S_SHIFT_READ;
                    end
                end
                else if (idx_plus1 == count_reg)
                begin
                    state_next = antd_pkg::S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = antd_pkg::S_OFF_READ;
                end
            end
            antd_pkg::S_SHIFT_READ:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_reg + IW'(1);
                state_next  = antd_pkg::S_SHIFT_WRITE;
            end
            antd_pkg::S_SHIFT_WRITE:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_entry = rd_entry;
                if (idx_plus2 == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = antd_pkg::S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = antd_pkg::S_SHIFT_READ;
                end
            end

            // Frame end: emit each entry and write back its decayed volume in the same state
            antd_pkg::S_FRAME_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = antd_pkg::S_FRAME_EMIT;
            end
            antd_pkg::S_FRAME_EMIT:
            begin
                if (!res_full)
                begin
                    res_push     = 1'b1;
                    res_data     = '{entry_valid: 1'b1, note: rd_entry.note,
                                     voice: rd_entry.voice, volume: rd_entry.volume,
                                     last_entry: (idx_plus1 == count_reg),
                                     overflow_seen: overflow_reg};
                    ram_wr_en    = 1'b1;
                    ram_wr_entry = '{note: rd_entry.note, voice: rd_entry.voice,
                                     volume: decayed_volume};
                    if (idx_plus1 == count_reg)
                    begin
                        state_next = antd_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = antd_pkg::S_FRAME_READ;
                    end
                end
            end
            antd_pkg::S_EMPTY:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    res_data   = '{entry_valid: 1'b0, note: '0, voice: '0, volume: '0,
                                   last_entry: 1'b1, overflow_seen: overflow_reg};
                    state_next = antd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = antd_pkg::S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= antd_pkg::S_IDLE;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // Hold the current command and walk index
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
    end

    antd_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    antd_fifo #(
        .WIDTH (RW),
        .DEPTH (antd_pkg::RES_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (res_pop),
        .empty (res_empty),
        .rdata (res_rdata)
    );

    assign res_word = res_rdata;

    // Table never holds more entries than it has rows
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // Overflow flag is sticky
    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag cleared");

    // Never push a result into a full queue
    a_res_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed while queue full");

    // Commands are taken only when idle and one is waiting
    a_cmd_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == antd_pkg::S_IDLE) && !cmd_empty)
        else $error("command popped outside idle");

    // Count only changes on completion of a note-on or note-off
    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_next != count_reg) |-> (state_reg == antd_pkg::S_ON_APPEND
                                      || state_reg == antd_pkg::S_OFF_CHECK
                                      || state_reg == antd_pkg::S_SHIFT_WRITE))
        else $error("entry count changed in wrong state");

endmodule

// ===== hdl/active_note_table_decay_top.sv =====
`timescale 1ns / 1ps
// Top level of the active note table with per-frame decay.
// Depends on antd_pkg, antd_front and antd_back.
//
//  channel   handshake              payload
//  request   push / full            req_type, note_number, channel_voice, note_velocity
//  result    empty / pop            entry_valid, out_note, out_voice, out_volume,
//                                   last_entry, overflow_seen
//  config    cfg_valid / cfg_ready  cfg_data (decay factor)
//
// Commands run one at a time in the back end: the idle state takes a command, then each
// table row visited passes a read state and a check, write or emit state, set by the
// registered read port of the table RAM; a full result queue stalls the frame walk.
// Reset clears the entry count, overflow flag and queues; decay returns to 243.
// A two-word command queue lets requests arrive while the back end is busy, and a
// four-word result queue lets the walk continue while results wait for pop.

module active_note_table_decay_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [antd_pkg::REQ_W-1:0]    req_type,
    input  logic [antd_pkg::NOTE_W-1:0]   note_number,
    input  logic [antd_pkg::VOICE_W-1:0]  channel_voice,
    input  logic [antd_pkg::VEL_W-1:0]    note_velocity,
    output logic                          empty,
    input  logic                          pop,
    output logic                          entry_valid,
    output logic [antd_pkg::NOTE_W-1:0]   out_note,
    output logic [antd_pkg::VOICE_W-1:0]  out_voice,
    output logic [antd_pkg::VOL_W-1:0]    out_volume,
    output logic                          last_entry,
    output logic                          overflow_seen,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [antd_pkg::FACT_W-1:0]   cfg_data
);

    logic [antd_pkg::FACT_W-1:0] decay_reg, decay_next;
    antd_pkg::cmd_t              cmd_word;
    logic                        cmd_empty;
    logic                        cmd_pop;
    antd_pkg::result_t           res_word;

    // Load the decay factor on a config word
    assign cfg_ready  = 1'b1;
    assign decay_next = (cfg_valid && cfg_ready) ? cfg_data : decay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= antd_pkg::DECAY_RESET;
        end
        else
        begin
            decay_reg <= decay_next;
        end
    end

    antd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .req_type      (req_type),
        .note_number   (note_number),
        .channel_voice (channel_voice),
        .note_velocity (note_velocity),
        .cmd_pop       (cmd_pop),
        .cmd_empty     (cmd_empty),
        .cmd_word      (cmd_word)
    );

    antd_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .decay_factor (decay_reg),
        .cmd_word     (cmd_word),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .res_pop      (pop),
        .res_empty    (empty),
        .res_word     (res_word)
    );

    // Drive result fields from the head of the result queue
    assign entry_valid   = res_word.entry_valid;
    assign out_note      = res_word.note;
    assign out_voice     = res_word.voice;
    assign out_volume    = res_word.volume;
    assign last_entry    = res_word.last_entry;
    assign overflow_seen = res_word.overflow_seen;

endmodule
